// ===== hdl/srect_pkg.sv =====
// Shared types, widths and sign helpers for the segment / rectangle touch test.
// No dependencies.
package srect_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // sign code: neither bit set means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  typedef struct packed {
    logic [3:0] cb;       // corner k inside segment bounding box
    logic [3:0] pb;       // first endpoint inside edge i bounding box
    logic [3:0] qb;       // second endpoint inside edge i bounding box
    sgn_t [3:0] s3;       // orientation of edge i against first endpoint
    sgn_t [3:0] s4;       // orientation of edge i against second endpoint
    logic       ep_hit;   // an endpoint lies in the rectangle
    logic       neq;      // endpoints differ
  } flags_t;

  typedef struct packed {
    diff_t      dx;
    diff_t      dy;
    diff_t [3:0] ux;
    diff_t [3:0] uy;
    flags_t     f;
  } prep_t;

  typedef struct packed {
    prod_t [3:0] m1;
    prod_t [3:0] m2;
    flags_t      f;
  } prod_stage_t;

  function automatic sgn_t cmp_sgn(input coord_t a, input coord_t b);
    sgn_t s;
    s.pos = (a > b);
    s.neg = (a < b);
    return s;
  endfunction

  function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
    sgn_t s;
    s.pos = (a.pos & b.pos) | (a.neg & b.neg);
    s.neg = (a.pos & b.neg) | (a.neg & b.pos);
    return s;
  endfunction

  // sign of sdx*suy - sdy*sux where at most one term is non-zero (axis-aligned edge)
  function automatic sgn_t orient_ax(input sgn_t sdx, input sgn_t sdy,
                                     input sgn_t suy, input sgn_t sux);
    sgn_t t1;
    sgn_t t2;
    sgn_t s;
    t1 = sgn_mul(sdx, suy);
    t2 = sgn_mul(sdy, sux);
    s.pos = t1.pos | t2.neg;
    s.neg = t1.neg | t2.pos;
    return s;
  endfunction

  function automatic logic in_range(input coord_t v, input coord_t a, input coord_t b);
    return ((v >= a) || (v >= b)) && ((v <= a) || (v <= b));
  endfunction

  function automatic logic sgn_cross(input sgn_t a, input sgn_t b);
    return (a.pos & b.neg) | (a.neg & b.pos);
  endfunction

  function automatic logic sgn_zero(input sgn_t a);
    return ~(a.pos | a.neg);
  endfunction

endpackage

// ===== hdl/srect_prep.sv =====
// Input register and first stage: coordinate differences, box compares and edge signs.
// Depends on srect_pkg.
module srect_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  srect_pkg::point_t   p_i,
  input  srect_pkg::point_t   q_i,
  input  srect_pkg::point_t   a_i,
  input  srect_pkg::point_t   c_i,
  output logic                vld_o,
  output srect_pkg::prep_t    prep_o
);
  import srect_pkg::*;

  logic   v0_r;
  point_t p_r, q_r, a_r, c_r;
  logic   v1_r;
  prep_t  prep_r, prep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_i;
    q_r    <= q_i;
    a_r    <= a_i;
    c_r    <= c_i;
    prep_r <= prep_nxt;
  end

  always_comb begin
    point_t     corner [4];
    logic [1:0] j;
    sgn_t       sex;
    sgn_t       sey;
    corner[0]   = a_r;
    corner[1].x = a_r.x;
    corner[1].y = c_r.y;
    corner[2]   = c_r;
    corner[3].x = c_r.x;
    corner[3].y = a_r.y;
    prep_nxt    = '0;
    prep_nxt.dx = diff_t'(q_r.x) - diff_t'(p_r.x);
    prep_nxt.dy = diff_t'(q_r.y) - diff_t'(p_r.y);
    for (int k = 0; k < 4; k++) begin
      j = 2'(k + 1);
      prep_nxt.ux[k]   = diff_t'(corner[k].x) - diff_t'(p_r.x);
      prep_nxt.uy[k]   = diff_t'(corner[k].y) - diff_t'(p_r.y);
      prep_nxt.f.cb[k] = in_range(corner[k].x, p_r.x, q_r.x) &&
                         in_range(corner[k].y, p_r.y, q_r.y);
      sex = cmp_sgn(corner[j].x, corner[k].x);
      sey = cmp_sgn(corner[j].y, corner[k].y);
      prep_nxt.f.s3[k] = orient_ax(sex, sey, cmp_sgn(p_r.y, corner[k].y),
                                   cmp_sgn(p_r.x, corner[k].x));
      prep_nxt.f.s4[k] = orient_ax(sex, sey, cmp_sgn(q_r.y, corner[k].y),
                                   cmp_sgn(q_r.x, corner[k].x));
      prep_nxt.f.pb[k] = in_range(p_r.x, corner[k].x, corner[j].x) &&
                         in_range(p_r.y, corner[k].y, corner[j].y);
      prep_nxt.f.qb[k] = in_range(q_r.x, corner[k].x, corner[j].x) &&
                         in_range(q_r.y, corner[k].y, corner[j].y);
    end
    prep_nxt.f.ep_hit = (in_range(p_r.x, a_r.x, c_r.x) && in_range(p_r.y, a_r.y, c_r.y)) ||
                        (in_range(q_r.x, a_r.x, c_r.x) && in_range(q_r.y, a_r.y, c_r.y));
    prep_nxt.f.neq    = (p_r != q_r);
  end

  assign vld_o  = v1_r;
  assign prep_o = prep_r;

endmodule

// ===== hdl/srect_mul.sv =====
// Product stage: the two cross-product terms of the segment against each corner.
// Depends on srect_pkg.
module srect_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  srect_pkg::prep_t         prep_i,
  output logic                     vld_o,
  output srect_pkg::prod_stage_t   prod_o
);
  import srect_pkg::*;

  logic        v_r;
  prod_stage_t prod_r, prod_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_comb begin
    prod_nxt.f = prep_i.f;
    for (int k = 0; k < 4; k++) begin
      prod_nxt.m1[k] = prod_t'($signed(prep_i.dx)) * prod_t'($signed(prep_i.uy[k]));
      prod_nxt.m2[k] = prod_t'($signed(prep_i.dy)) * prod_t'($signed(prep_i.ux[k]));
    end
  end

  assign vld_o  = v_r;
  assign prod_o = prod_r;

endmodule

// ===== hdl/srect_judge.sv =====
// Sign compare of the cross products, then per-edge meet test and output register.
// Depends on srect_pkg.
module srect_judge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld_i,
  input  srect_pkg::prod_stage_t   prod_i,
  output logic                     vld_o,
  output logic                     hit_o
);
  import srect_pkg::*;

  logic       v3_r;
  sgn_t [3:0] s_r, s_nxt;
  flags_t     f_r;
  logic       vo_r;
  logic       hit_r, hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v3_r <= vld_i;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    f_r   <= prod_i.f;
    hit_r <= hit_nxt;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_nxt[k].pos = $signed(prod_i.m1[k]) > $signed(prod_i.m2[k]);
      s_nxt[k].neg = $signed(prod_i.m1[k]) < $signed(prod_i.m2[k]);
    end
  end

  always_comb begin
    logic [3:0] meet;
    logic [1:0] j;
    for (int k = 0; k < 4; k++) begin
      j = 2'(k + 1);
      meet[k] = (sgn_cross(s_r[k], s_r[j]) && sgn_cross(f_r.s3[k], f_r.s4[k])) ||
                (sgn_zero(s_r[k]) && f_r.cb[k]) ||
                (sgn_zero(s_r[j]) && f_r.cb[j]) ||
                (sgn_zero(f_r.s3[k]) && f_r.pb[k]) ||
                (sgn_zero(f_r.s4[k]) && f_r.qb[k]);
    end
    hit_nxt = f_r.ep_hit || (f_r.neq && (|meet));
  end

  assign vld_o = vo_r;
  assign hit_o = hit_r;

endmodule

// ===== hdl/segment_rectangle_intersect.sv =====
// Top level of the segment / rectangle touch test: five-stage pipeline.
// Depends on srect_pkg, srect_prep, srect_mul, srect_judge.
//
//   channel | ports                                  | transfer
//   --------+----------------------------------------+---------------------------
//   input   | start, busy, in_seg_*, in_rect_*       | edge with start & !busy
//   result  | out_valid, out_hit                     | each cycle out_valid is high
//
// One query per clock; out_valid follows start through the input register,
// compare stage, multiplier stage, sign compare and output register.
// busy is held low: the result side cannot stall, so the pipeline always advances.
// rst_n (synchronous) clears the valid bits only.
module segment_rectangle_intersect (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  srect_pkg::coord_t      in_seg_start_x,
  input  srect_pkg::coord_t      in_seg_start_y,
  input  srect_pkg::coord_t      in_seg_end_x,
  input  srect_pkg::coord_t      in_seg_end_y,
  input  srect_pkg::coord_t      in_rect_corner1_x,
  input  srect_pkg::coord_t      in_rect_corner1_y,
  input  srect_pkg::coord_t      in_rect_corner2_x,
  input  srect_pkg::coord_t      in_rect_corner2_y,
  output logic                   out_valid,
  output logic                   out_hit
);
  import srect_pkg::*;

  point_t      p, q, a, c;
  logic        v1, v2;
  prep_t       prep;
  prod_stage_t prod;

  assign busy = 1'b0;

  assign p.x = in_seg_start_x;
  assign p.y = in_seg_start_y;
  assign q.x = in_seg_end_x;
  assign q.y = in_seg_end_y;
  assign a.x = in_rect_corner1_x;
  assign a.y = in_rect_corner1_y;
  assign c.x = in_rect_corner2_x;
  assign c.y = in_rect_corner2_y;

  srect_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start & ~busy),
    .p_i    (p),
    .q_i    (q),
    .a_i    (a),
    .c_i    (c),
    .vld_o  (v1),
    .prep_o (prep)
  );

  srect_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v1),
    .prep_i (prep),
    .vld_o  (v2),
    .prod_o (prod)
  );

  srect_judge u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v2),
    .prod_i (prod),
    .vld_o  (out_valid),
    .hit_o  (out_hit)
  );

endmodule
